// ===== sv/binned_rms_feature_l2_norm_defines.svh =====
// assertion helpers for the binned rms feature block
`ifndef BINNED_RMS_FEATURE_L2_NORM_DEFINES_SVH
`define BINNED_RMS_FEATURE_L2_NORM_DEFINES_SVH

// property that must hold in the cycle after a trigger
`define BRF_ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("check failed");

// property that must hold in the same cycle as a trigger
`define BRF_ASSERT_NOW(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("check failed");

`endif

// ===== sv/brf_pkg.sv =====
package brf_pkg;

    localparam int FeatureBins = 32;
    localparam int BinBits = 5;
    localparam int EnergyBits = 50;
    localparam int RmsBits = 16;
    localparam int LenBits = 17;
    localparam int MaxFrames = 65536;
    localparam int MaxChannels = 8;
    localparam int SumBits = 37;
    localparam int QuotBits = 64;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [16:0]        segment_length;
        logic [15:0]        seg_tag;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]  bin_index;
        logic [15:0] feature_value;
        logic [15:0] seg_tag_out;
        logic        last;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ACC,
        ST_RMS_RD,
        ST_RMS_DIV,
        ST_RMS_SQRT,
        ST_SUM_RD,
        ST_SUM_ADD,
        ST_OUT_RD,
        ST_OUT_DIV,
        ST_OUT_SQRT,
        ST_OUT_EMIT
    } state_t;

    // start/result handshake between control and the shared divide/sqrt unit
    typedef struct packed {
        logic div_start;
        logic sqrt_start;
    } math_ctl_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
    } math_sts_t;

endpackage

// ===== sv/brf_ram.sv =====
module brf_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== sv/brf_math.sv =====
module brf_math (
    input  logic                             clk,
    input  logic                             rst_n,
    input  brf_pkg::math_ctl_t               ctl,
    input  logic [brf_pkg::QuotBits-1:0]     num,
    input  logic [brf_pkg::QuotBits-1:0]     den,
    input  logic [brf_pkg::QuotBits-1:0]     root_in,
    output brf_pkg::math_sts_t               sts,
    output logic [brf_pkg::QuotBits-1:0]     quot,
    output logic [brf_pkg::QuotBits/2-1:0]   root
);
    import brf_pkg::*;

    // restoring divider, one quotient bit a cycle
    logic [QuotBits-1:0] rem_reg, rem_next;
    logic [QuotBits-1:0] q_reg, q_next;
    logic [QuotBits-1:0] d_reg, d_next;
    logic [6:0]          dcnt_reg, dcnt_next;
    logic                dbusy_reg, dbusy_next;
    logic [QuotBits:0]   trial;

    // bit-pair square root, one result bit a cycle
    logic [QuotBits-1:0]   x_reg, x_next;
    logic [QuotBits+1:0]   r_reg, r_next;
    logic [QuotBits/2-1:0] s_reg, s_next;
    logic [5:0]            scnt_reg, scnt_next;
    logic                  sbusy_reg, sbusy_next;
    logic [QuotBits+1:0]   r_sh;
    logic [QuotBits+1:0]   t_sq;

    always_comb
    begin
        rem_next   = rem_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        dcnt_next  = dcnt_reg;
        dbusy_next = dbusy_reg;
        trial      = '0;
        if (ctl.div_start)
        begin
            rem_next   = '0;
            q_next     = num;
            d_next     = den;
            dcnt_next  = 7'(QuotBits);
            dbusy_next = 1'b1;
        end
        else if (dbusy_reg)
        begin
            trial = {rem_reg, q_reg[QuotBits-1]} - {1'b0, d_reg};
            if (!trial[QuotBits])
            begin
                rem_next = trial[QuotBits-1:0];
                q_next   = {q_reg[QuotBits-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[QuotBits-2:0], q_reg[QuotBits-1]};
                q_next   = {q_reg[QuotBits-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg - 7'd1;
            if (dcnt_reg == 7'd1)
            begin
                dbusy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        x_next     = x_reg;
        r_next     = r_reg;
        s_next     = s_reg;
        scnt_next  = scnt_reg;
        sbusy_next = sbusy_reg;
        r_sh       = {r_reg[QuotBits-1:0], x_reg[QuotBits-1:QuotBits-2]};
        t_sq       = {{(QuotBits/2){1'b0}}, s_reg, 2'b01};
        if (ctl.sqrt_start)
        begin
            x_next     = root_in;
            r_next     = '0;
            s_next     = '0;
            scnt_next  = 6'(QuotBits/2);
            sbusy_next = 1'b1;
        end
        else if (sbusy_reg)
        begin
            x_next = {x_reg[QuotBits-3:0], 2'b00};
            if (r_sh >= t_sq)
            begin
                r_next = r_sh - t_sq;
                s_next = {s_reg[QuotBits/2-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh;
                s_next = {s_reg[QuotBits/2-2:0], 1'b0};
            end
            scnt_next = scnt_reg - 6'd1;
            if (scnt_reg == 6'd1)
            begin
                sbusy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg  <= '0;
            dbusy_reg <= 1'b0;
            scnt_reg  <= '0;
            sbusy_reg <= 1'b0;
        end
        else
        begin
            dcnt_reg  <= dcnt_next;
            dbusy_reg <= dbusy_next;
            scnt_reg  <= scnt_next;
            sbusy_reg <= sbusy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        x_reg   <= x_next;
        r_reg   <= r_next;
        s_reg   <= s_next;
    end

    assign sts.div_busy  = dbusy_reg;
    assign sts.sqrt_busy = sbusy_reg;
    assign quot          = q_reg;
    assign root          = s_reg;

endmodule

// ===== sv/binned_rms_feature_l2_norm.sv =====
// binned rms energy feature, l2 normalized, 32 bins per segment
// sequence: the first beat starts a clear of all bins, then one sample beat a cycle;
// after the last sample the rms of each bin, then the sum of squares, then one
// normalized result per bin (divide and sqrt skipped when all bins are zero)
// throughput: busy during clear and finishing; the receiver cannot stall
// reset: control state cleared, num_channels back to 2, memories cleared per segment
module binned_rms_feature_l2_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  brf_pkg::in_beat_t in_beat,
    output logic              busy,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_wdata,
    output logic              result_valid,
    output brf_pkg::out_beat_t result
);
    import brf_pkg::*;

`include "binned_rms_feature_l2_norm_defines.svh"

    state_t state_reg, state_next;

    logic [3:0]         nch_reg, nch_next;
    logic [3:0]         hch_reg, hch_next;
    logic [LenBits-1:0] len_reg, len_next;
    logic [15:0]        id_reg, id_next;
    logic [LenBits-1:0] frame_reg, frame_next;
    logic [3:0]         chan_reg, chan_next;
    logic [11:0]        wcnt_reg, wcnt_next;   // frames left in current bin
    logic [11:0]        width_reg, width_next;
    logic [BinBits:0]   bin_reg, bin_next;     // bin of the sample beat; 32 = tail
    logic [BinBits:0]   idx_reg, idx_next;     // sweep index
    logic [SumBits-1:0] total_reg, total_next;
    logic [15:0]        pend_sample_reg, pend_sample_next;
    logic               pend_reg, pend_next;

    // energy accumulate pipe: read issued with the sample beat, add and write in the following cycle
    logic               acc_v_reg;
    logic [BinBits-1:0] acc_bin_reg;
    logic [31:0]        acc_sq_reg;
    logic [EnergyBits-1:0] fwd_reg;
    logic               fwd_v_reg;
    logic [BinBits-1:0] fwd_bin_reg;

    logic               e_we, r_we;
    logic [BinBits-1:0] e_waddr, e_raddr, r_waddr, r_raddr;
    logic [EnergyBits-1:0] e_wdata, e_rdata, e_old;
    logic [RmsBits-1:0] r_wdata, r_rdata;

    math_ctl_t           mctl;
    math_sts_t           msts;
    logic [QuotBits-1:0] m_num, m_den, m_root_in, m_quot;
    logic [QuotBits/2-1:0] m_root;

    logic               accept, acc_fire;
    logic [15:0]        mag;
    logic [16:0]        len_sat;
    logic [3:0]         ch_sat;
    logic               seg_end;
    logic [15:0]        fval;
    logic               emit;

    brf_ram #(.Width(EnergyBits), .Depth(FeatureBins)) u_energy (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    brf_ram #(.Width(RmsBits), .Depth(FeatureBins)) u_rms (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    brf_math u_math (
        .clk(clk), .rst_n(rst_n), .ctl(mctl), .num(m_num), .den(m_den),
        .root_in(m_root_in), .sts(msts), .quot(m_quot), .root(m_root)
    );

    assign accept = start && !busy;
    assign busy   = !(state_reg == ST_IDLE || state_reg == ST_ACC);
    assign mag    = in_beat.sample[15] ? 16'(-in_beat.sample) : in_beat.sample;
    assign len_sat = (in_beat.segment_length > 17'(MaxFrames)) ? 17'(MaxFrames)
                                                              : in_beat.segment_length;
    assign ch_sat  = (nch_reg > 4'(MaxChannels)) ? 4'(MaxChannels) : nch_reg;

    // forward the just-written energy to a back-to-back beat of the same bin
    assign e_old = (fwd_v_reg && fwd_bin_reg == acc_bin_reg) ? fwd_reg : e_rdata;

    always_comb
    begin
        if (m_root[QuotBits/2-1:16] != '0)
        begin
            fval = 16'hFFFF;
        end
        else
        begin
            fval = m_root[15:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        nch_next         = nch_reg;
        hch_next         = hch_reg;
        len_next         = len_reg;
        id_next          = id_reg;
        frame_next       = frame_reg;
        chan_next        = chan_reg;
        wcnt_next        = wcnt_reg;
        width_next       = width_reg;
        bin_next         = bin_reg;
        idx_next         = idx_reg;
        total_next       = total_reg;
        pend_sample_next = pend_sample_reg;
        pend_next        = pend_reg;
        acc_fire         = 1'b0;
        seg_end          = 1'b0;
        // read for the sample beat fired this cycle
        e_raddr          = bin_reg[BinBits-1:0];
        r_we             = 1'b0;
        r_waddr          = idx_reg[BinBits-1:0];
        r_wdata          = '0;
        r_raddr          = idx_reg[BinBits-1:0];
        mctl             = '0;
        m_num            = '0;
        m_den            = '0;
        m_root_in        = '0;
        emit             = 1'b0;

        if (cfg_we)
        begin
            nch_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    len_next   = len_sat;
                    id_next    = in_beat.seg_tag;
                    hch_next   = ch_sat;
                    frame_next = '0;
                    chan_next  = '0;
                    bin_next   = '0;
                    width_next = (len_sat[16:5] == '0) ? 12'd1 : len_sat[16:5];
                    wcnt_next  = (len_sat[16:5] == '0) ? 12'd1 : len_sat[16:5];
                    idx_next   = '0;
                    total_next = '0;
                    pend_sample_next = mag;
                    pend_next  = (len_sat != '0) && (ch_sat != '0);
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                r_we     = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 6'(FeatureBins - 1))
                begin
                    idx_next = '0;
                    if (pend_reg)
                    begin
                        acc_fire  = 1'b1;
                        pend_next = 1'b0;
                        state_next = ST_ACC;
                    end
                    else
                    begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_ACC:
            begin
                if (accept)
                begin
                    pend_sample_next = mag;
                    acc_fire = 1'b1;
                end
            end
            ST_RMS_RD:
            begin
                if (!acc_v_reg)
                begin
                    e_raddr  = idx_reg[BinBits-1:0];
                    state_next = ST_RMS_DIV;
                end
            end
            ST_RMS_DIV:
            begin
                mctl.div_start = 1'b1;
                m_num = 64'(e_rdata);
                m_den = 64'({4'd0, width_reg} * {12'd0, hch_reg});
                state_next = ST_RMS_SQRT;
            end
            ST_RMS_SQRT:
            begin
                if (!msts.div_busy && !msts.sqrt_busy)
                begin
                    if (wcnt_reg == 12'd0)
                    begin
                        // sqrt done, store
                        r_we    = 1'b1;
                        r_wdata = ((17'(idx_reg) * 17'(width_reg)) < len_reg)
                                  ? m_root[15:0] : 16'd0;
                        wcnt_next = 12'd1;
                        idx_next  = idx_reg + 1'b1;
                        if (idx_reg == 6'(FeatureBins - 1))
                        begin
                            idx_next   = '0;
                            state_next = ST_SUM_RD;
                        end
                        else
                        begin
                            state_next = ST_RMS_RD;
                        end
                    end
                    else
                    begin
                        mctl.sqrt_start = 1'b1;
                        m_root_in = m_quot;
                        wcnt_next = 12'd0;
                    end
                end
            end
            ST_SUM_RD:
            begin
                state_next = ST_SUM_ADD;
            end
            ST_SUM_ADD:
            begin
                total_next = total_reg + SumBits'(32'(r_rdata) * 32'(r_rdata));
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SUM_RD;
                if (idx_reg == 6'(FeatureBins - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD:
            begin
                wcnt_next  = 12'd1;
                state_next = ST_OUT_DIV;
            end
            ST_OUT_DIV:
            begin
                if (total_reg == '0)
                begin
                    wcnt_next  = 12'd0;
                    state_next = ST_OUT_EMIT;
                end
                else
                begin
                    mctl.div_start = 1'b1;
                    m_num = {32'(r_rdata) * 32'(r_rdata), 32'd0};
                    m_den = 64'(total_reg);
                    state_next = ST_OUT_SQRT;
                end
            end
            ST_OUT_SQRT:
            begin
                if (!msts.div_busy && !msts.sqrt_busy)
                begin
                    if (wcnt_reg == 12'd0)
                    begin
                        wcnt_next  = 12'd1;
                        state_next = ST_OUT_EMIT;
                    end
                    else
                    begin
                        mctl.sqrt_start = 1'b1;
                        m_root_in = m_quot;
                        wcnt_next = 12'd0;
                    end
                end
            end
            ST_OUT_EMIT:
            begin
                emit     = 1'b1;
                idx_next = idx_reg + 1'b1;
                state_next = ST_OUT_RD;
                if (idx_reg == 6'(FeatureBins - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // frame and bin tracking for each accepted sample beat
        if (acc_fire)
        begin
            chan_next = chan_reg + 4'd1;
            if (chan_reg + 4'd1 >= hch_reg)
            begin
                chan_next  = '0;
                frame_next = frame_reg + 1'b1;
                if (bin_reg != 6'(FeatureBins))
                begin
                    wcnt_next = wcnt_reg - 12'd1;
                    if (wcnt_reg == 12'd1)
                    begin
                        wcnt_next = width_reg;
                        bin_next  = bin_reg + 1'b1;
                    end
                end
                if (frame_reg + 1'b1 >= len_reg)
                begin
                    seg_end    = 1'b1;
                    idx_next   = '0;
                    wcnt_next  = 12'd1;
                    state_next = ST_RMS_RD;
                end
            end
        end
    end

    // energy read-modify-write; zeroes are written during the clear
    assign e_we    = acc_v_reg || (state_reg == ST_CLEAR);
    assign e_waddr = (state_reg == ST_CLEAR) ? idx_reg[BinBits-1:0] : acc_bin_reg;
    assign e_wdata = (state_reg == ST_CLEAR) ? '0 : e_old + EnergyBits'(acc_sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nch_reg   <= 4'd2;
            hch_reg   <= '0;
            len_reg   <= '0;
            id_reg    <= '0;
            frame_reg <= '0;
            chan_reg  <= '0;
            wcnt_reg  <= '0;
            width_reg <= '0;
            bin_reg   <= '0;
            idx_reg   <= '0;
            total_reg <= '0;
            pend_reg  <= 1'b0;
            acc_v_reg <= 1'b0;
            fwd_v_reg <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nch_reg   <= nch_next;
            hch_reg   <= hch_next;
            len_reg   <= len_next;
            id_reg    <= id_next;
            frame_reg <= frame_next;
            chan_reg  <= chan_next;
            wcnt_reg  <= wcnt_next;
            width_reg <= width_next;
            bin_reg   <= bin_next;
            idx_reg   <= idx_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
            acc_v_reg <= acc_fire && (bin_reg != 6'(FeatureBins));
            fwd_v_reg <= acc_v_reg;
            result_valid <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_sample_reg <= pend_sample_next;
        acc_bin_reg <= bin_reg[BinBits-1:0];
        acc_sq_reg  <= 32'(pend_sample_next) * 32'(pend_sample_next);
        fwd_reg     <= e_wdata;
        fwd_bin_reg <= acc_bin_reg;
        if (emit)
        begin
            result.bin_index     <= idx_reg[BinBits-1:0];
            result.feature_value <= (total_reg == '0) ? 16'd0 : fval;
            result.seg_tag_out   <= id_reg;
            result.last          <= (idx_reg == 6'(FeatureBins - 1));
        end
    end

    `BRF_ASSERT_NOW(a_no_emit_busy_low, result_valid && $past(emit) == 1'b0, 1'b0)
    `BRF_ASSERT_NEXT(a_end_goes_finish, seg_end, state_reg == ST_RMS_RD)
    `BRF_ASSERT_NOW(a_math_exclusive, mctl.div_start, !msts.div_busy)

endmodule

// ===== tb/binned_rms_feature_l2_norm_checker.sv =====
`timescale 1ns / 100ps

module binned_rms_feature_l2_norm_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  brf_pkg::in_beat_t  in_beat,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  logic               result_valid,
    input  brf_pkg::out_beat_t result,
    output int                 fail_count,
    output int                 pending
);
    import brf_pkg::*;

    logic [3:0]  chan_reg;
    logic [49:0] energy [FeatureBins];
    logic [15:0] rms [FeatureBins];
    logic [16:0] frame_cnt;
    logic [3:0]  chan_cnt;
    logic [16:0] seg_len;
    logic [15:0] seg_id;
    logic        open_seg;
    logic [3:0]  seg_chans;
    out_beat_t   feature_q[$];

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [16:0] width_of(logic [16:0] len);
        logic [16:0] w;
        w = len / FeatureBins;
        return (w == 0) ? 17'd1 : w;
    endfunction

    task automatic queue_features();
        logic [63:0] total;
        logic [63:0] sq;
        logic [63:0] v;
        out_beat_t   o;
        total = 0;
        for (int b = 0; b < FeatureBins; b++)
            total += 64'(rms[b]) * rms[b];
        for (int b = 0; b < FeatureBins; b++)
        begin
            v = 0;
            if (total != 0)
            begin
                sq = 64'(rms[b]) * rms[b];
                v = int_sqrt((sq << 32) / total);
                if (v > 65535)
                    v = 65535;
            end
            o.bin_index = b[4:0];
            o.feature_value = v[15:0];
            o.seg_tag_out = seg_id;
            o.last = (b == FeatureBins - 1);
            feature_q = {feature_q, o};
        end
    endtask

    task automatic finish_rms();
        logic [16:0] w;
        logic [63:0] cnt;
        w = width_of(seg_len);
        cnt = 64'(w) * seg_chans;
        for (int b = 0; b < FeatureBins; b++)
        begin
            if (64'(b) * w < seg_len && cnt != 0)
                rms[b] = 16'(int_sqrt(64'(energy[b]) / cnt));
            else
                rms[b] = 0;
        end
    endtask

    task automatic absorb_sample(in_beat_t ib);
        logic [16:0] len;
        logic [3:0]  ch;
        logic [15:0] mag;
        logic [16:0] bin;
        if (!open_seg)
        begin
            len = (ib.segment_length > MaxFrames) ? 17'(MaxFrames) : ib.segment_length;
            ch = (chan_reg > MaxChannels) ? 4'(MaxChannels) : chan_reg;
            seg_len = len;
            seg_id = ib.seg_tag;
            seg_chans = ch;
            for (int b = 0; b < FeatureBins; b++)
            begin
                energy[b] = 0;
                rms[b] = 0;
            end
            frame_cnt = 0;
            chan_cnt = 0;
            if (len == 0 || ch == 0)
            begin
                queue_features();
                return;
            end
            open_seg = 1;
        end
        mag = ib.sample[15] ? 16'(-ib.sample) : ib.sample;
        bin = frame_cnt / width_of(seg_len);
        if (bin < FeatureBins)
            energy[bin] += 50'(32'(mag) * mag);
        chan_cnt++;
        if (chan_cnt >= seg_chans)
        begin
            chan_cnt = 0;
            frame_cnt++;
            if (frame_cnt >= seg_len)
            begin
                open_seg = 0;
                finish_rms();
                queue_features();
            end
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t w;
        if (!rst_n)
        begin
            chan_reg = 2;
            open_seg = 0;
            frame_cnt = 0;
            chan_cnt = 0;
            seg_len = 0;
            seg_id = 0;
            seg_chans = 0;
            fail_count = 0;
            feature_q.delete();
        end
        else
        begin
            // compare against what was queued before this edge's sample beat
            if (result_valid)
            begin
                if (feature_q.size() == 0)
                    report_mismatch("unexpected beat, bin", result.bin_index, -1);
                else
                begin
                    w = feature_q.pop_front();
                    if (result.bin_index !== w.bin_index)
                        report_mismatch("bin_index", result.bin_index, w.bin_index);
                    if (result.feature_value !== w.feature_value)
                        report_mismatch("feature_value", result.feature_value,
                                        w.feature_value);
                    if (result.seg_tag_out !== w.seg_tag_out)
                        report_mismatch("seg_tag_out", result.seg_tag_out,
                                        w.seg_tag_out);
                    if (result.last !== w.last)
                        report_mismatch("last", result.last, w.last);
                end
            end
            if (start && !busy)
                absorb_sample(in_beat);
            if (cfg_we)
                chan_reg = cfg_wdata;
        end
        pending = feature_q.size();
    end
endmodule

// ===== tb/binned_rms_feature_l2_norm_tb.sv =====
`timescale 1ns / 100ps

module binned_rms_feature_l2_norm_tb;
    import brf_pkg::*;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      start = 0;
    in_beat_t  in_beat = '0;
    logic      busy;
    logic      cfg_we = 0;
    logic [3:0] cfg_wdata = 0;
    logic      result_valid;
    out_beat_t result;
    int        fail_count;
    int        pending;
    int        idle_cycles = 0;
    int        items_done = 0;
    bit        timed_out = 0;

    localparam int IdleLimit = 200000;

    always #5 clk = ~clk;

    binned_rms_feature_l2_norm dut (
        .clk(clk), .rst_n(rst_n), .start(start), .in_beat(in_beat), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .result(result)
    );

    binned_rms_feature_l2_norm_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .result_valid(result_valid),
        .result(result), .fail_count(fail_count), .pending(pending)
    );

    // watchdog: cycles with neither a sample beat nor a result beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (n != 0)
        begin
            start <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    // one sample beat: hold start until the block takes it
    task automatic send_beat(logic signed [15:0] s, logic [16:0] len, logic [15:0] id,
                             bit gaps);
        start <= 1;
        in_beat <= '{sample: s, segment_length: len, seg_tag: id};
        do
            @(posedge clk);
        while (busy);
        items_done++;
        if (gaps && $urandom_range(0, 3) == 0)
            idle_gap();
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // let the last result beat settle
        repeat (20) @(posedge clk);
    endtask

    task automatic write_channels(logic [3:0] v);
        drain();
        while (busy)
            @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // a full segment of random, extreme or zero content; beats = len * channels
    task automatic send_segment(logic [16:0] len, int chans, int kind, bit gaps);
        int beats;
        logic [15:0] id;
        logic signed [15:0] s;
        id = 16'($urandom_range(0, 65535));
        beats = (len > MaxFrames ? MaxFrames : len) * chans;
        if (beats == 0)
            beats = 1;
        for (int i = 0; i < beats; i++)
        begin
            case (kind)
                0: s = 16'($urandom_range(0, 65535));
                1: s = -16'sd32768;
                2: s = 16'sd32767;
                default: s = 0;
            endcase
            send_beat(s, (i == 0) ? len : 17'($urandom_range(0, 131071)),
                      (i == 0) ? id : 16'($urandom_range(0, 65535)), gaps);
        end
    endtask

    int chans;
    int lens[$] = '{1, 2, 3, 5, 17, 31, 32, 33};

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: zero-length, extremes, short/long segments at reset channels
        send_beat(16'sd1234, 17'd0, 16'hffff, 1'b0);
        send_segment(17'd1, 2, 1, 1'b0);
        send_segment(17'd3, 2, 2, 1'b0);
        send_segment(17'd2, 2, 3, 1'b0);
        send_segment(17'd33, 2, 0, 1'b0);
        // zero channels acts like an empty segment
        write_channels(4'd0);
        send_beat(-16'sd5, 17'd100, 16'h0000, 1'b0);
        // more than the maximum channel count saturates
        write_channels(4'd15);
        send_segment(17'd2, 8, 0, 1'b0);
        write_channels(4'd1);
        send_segment(17'd32, 1, 0, 1'b0);
        // register change mid-segment only applies at the next start
        send_beat(16'sd100, 17'd2, 16'h5a5a, 1'b0);
        write_channels(4'd8);
        send_beat(16'sd200, 17'd2, 16'h0, 1'b0);
        drain();
        send_segment(17'd1, 8, 0, 1'b0);

        // random phases
        while (items_done < 320)
        begin
            chans = $urandom_range(1, 4);
            write_channels(chans[3:0]);
            repeat ($urandom_range(1, 3))
            begin
                if (items_done < 320)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_beat(16'($urandom_range(0, 65535)), 17'd0,
                                  16'($urandom_range(0, 65535)), 1'b1);
                    else
                        send_segment(17'(lens[$urandom_range(0, lens.size() - 1)]), chans,
                                     ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 3),
                                     1'b1);
                end
            end
        end
        drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/brf_pkg.sv
sv/brf_ram.sv
sv/brf_math.sv
sv/binned_rms_feature_l2_norm.sv
tb/binned_rms_feature_l2_norm_checker.sv
tb/binned_rms_feature_l2_norm_tb.sv
